### hdl/rsec_pkg.sv
// Shared types, constants and register codes of the sensor event conditioner.
package rsec_pkg;

  localparam int LEVEL_W     = 10;
  localparam int BUMP_PORT_W = 8;
  localparam int VALUE_W     = 8;
  localparam int KIND_W      = 3;
  localparam int CFG_INDEX_W = 8;
  localparam int NUM_EV      = 4;

  localparam int DEF_HISTORY_DEPTH = 8;
  localparam int DEF_BUMPER_WIDTH  = 8;
  localparam int DEF_QUEUE_DEPTH   = 4;

  // Threshold reset values
  localparam logic [LEVEL_W-1:0] RST_BEACON_HIGH = LEVEL_W'(750);
  localparam logic [LEVEL_W-1:0] RST_BEACON_LOW  = LEVEL_W'(350);
  localparam logic [LEVEL_W-1:0] RST_TRACK_HIGH  = LEVEL_W'(400);
  localparam logic [LEVEL_W-1:0] RST_TRACK_LOW   = LEVEL_W'(300);

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_BEACON_HIGH = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_BEACON_LOW  = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] CFG_TRACK_HIGH  = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] CFG_TRACK_LOW   = CFG_INDEX_W'(3);

  // Event mask bit positions, in emission order
  localparam int EVB_BEACON = 0;
  localparam int EVB_BUMPER = 1;
  localparam int EVB_TOP    = 2;
  localparam int EVB_TRACK  = 3;

  typedef enum logic [KIND_W-1:0] {
    EV_BEACON_FOUND = 3'd0,
    EV_BEACON_LOST  = 3'd1,
    EV_BUMPER       = 3'd2,
    EV_TOP_BUMPER   = 3'd3,
    EV_TRACK_FOUND  = 3'd4,
    EV_TRACK_LOST   = 3'd5
  } ev_kind_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] beacon_hi;
    logic [LEVEL_W-1:0] beacon_lo;
    logic [LEVEL_W-1:0] track_hi;
    logic [LEVEL_W-1:0] track_lo;
  } cfg_t;

  // One tick's worth of events, as queued between front and back
  typedef struct packed {
    logic [NUM_EV-1:0]  mask;
    logic               beacon_on;
    logic [VALUE_W-1:0] bump_val;
    logic [VALUE_W-1:0] top_val;
    logic               track_found;
    logic [1:0]         track_flags;
  } rsec_rec_t;

endpackage

### hdl/robot_sensor_event_conditioner_unit.sv
// Top level of the robot sensor event conditioner.
//
// Each transfer on the input side is one sampling tick: a beacon level, two
// bumper bit sets and the right/left track-wire levels. The beacon goes through
// a hysteresis detector, each bumper set is debounced over the last
// HISTORY_DEPTH samples, and the track wire uses dual hysteresis with one flag
// per side (bit0 right, bit1 left). A tick yields zero to four events, always
// ordered beacon, bumper, top bumper, track, and the final event of a tick has
// last_event set. Throughput: the front end takes one tick per clock as long as
// the record queue (QUEUE_DEPTH entries) has room; the back end puts out one
// event per clock while its output register is empty or popped. The events of
// a tick reach the result side through the record queue and the output
// register. Thresholds are written through the cfg channel, which is always
// ready; writes to indexes above 3 are dropped. Write thresholds only while no
// tick is in flight.
module robot_sensor_event_conditioner_unit
  import rsec_pkg::*;
#(
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
  parameter int BUMPER_WIDTH  = DEF_BUMPER_WIDTH,
  parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // tick input
  input  logic                   in_push,
  output logic                   in_full,
  input  logic [LEVEL_W-1:0]     in_beacon_level,
  input  logic [BUMP_PORT_W-1:0] in_bumper_bits,
  input  logic [BUMP_PORT_W-1:0] in_top_bumper_bits,
  input  logic [LEVEL_W-1:0]     in_track_right_level,
  input  logic [LEVEL_W-1:0]     in_track_left_level,
  // event output
  output logic                   out_empty,
  input  logic                   out_pop,
  output logic [KIND_W-1:0]      out_event_kind,
  output logic [VALUE_W-1:0]     out_event_value,
  output logic                   out_last_event,
  // threshold writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [LEVEL_W-1:0]     cfg_data
);

  cfg_t      cfg_r, cfg_nxt;
  logic      q_full, q_empty, q_wr, q_rd;
  rsec_rec_t q_wdata, q_rdata;

  // Threshold registers: registered writes, never back-pressured.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BEACON_HIGH: cfg_nxt.beacon_hi = cfg_data;
        CFG_BEACON_LOW:  cfg_nxt.beacon_lo = cfg_data;
        CFG_TRACK_HIGH:  cfg_nxt.track_hi  = cfg_data;
        CFG_TRACK_LOW:   cfg_nxt.track_lo  = cfg_data;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.beacon_hi <= RST_BEACON_HIGH;
      cfg_r.beacon_lo <= RST_BEACON_LOW;
      cfg_r.track_hi  <= RST_TRACK_HIGH;
      cfg_r.track_lo  <= RST_TRACK_LOW;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: detectors and debounce, one tick per clock while the queue has room.
  rsec_front #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .BUMPER_WIDTH  (BUMPER_WIDTH)
  ) u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_beacon_level      (in_beacon_level),
    .in_bumper_bits       (in_bumper_bits),
    .in_top_bumper_bits   (in_top_bumper_bits),
    .in_track_right_level (in_track_right_level),
    .in_track_left_level  (in_track_left_level),
    .q_full               (q_full),
    .q_wr                 (q_wr),
    .q_data               (q_wdata)
  );

  // Queue of tick records; decouples tick intake from event drain.
  rsec_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  // Back: one event per clock into the output register while it is empty or popped.
  rsec_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_data          (q_rdata),
    .q_empty         (q_empty),
    .q_rd            (q_rd),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_event_kind  (out_event_kind),
    .out_event_value (out_event_value),
    .out_last_event  (out_last_event)
  );

endmodule

### hdl/rsec_debounce.sv
// Debounce of one bumper bit set over a ring of past samples.
module rsec_debounce
  import rsec_pkg::*;
#(
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
  parameter int BUMPER_WIDTH  = DEF_BUMPER_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic [BUMPER_WIDTH-1:0] sample,
  output logic                    ev
);

  localparam int SLOT_W = $clog2(HISTORY_DEPTH);

  logic [BUMPER_WIDTH-1:0] hist_r [HISTORY_DEPTH];
  logic [SLOT_W-1:0]       slot_r, slot_nxt;
  logic [BUMPER_WIDTH-1:0] rep_r, rep_nxt;
  logic                    stable;

  // The slot being written matches by definition; check the others.
  always_comb begin
    stable = 1'b1;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (SLOT_W'(i) != slot_r && hist_r[i] != sample) begin
        stable = 1'b0;
      end
    end
  end

  assign ev = stable && (sample != '0) && (sample != rep_r);

  always_comb begin
    slot_nxt = (slot_r == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_r + 1'b1;
    if (sample == '0) begin
      rep_nxt = '0;
    end else if (ev) begin
      rep_nxt = sample;
    end else begin
      rep_nxt = rep_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
      slot_r <= '0;
      rep_r  <= '0;
    end else if (en) begin
      hist_r[slot_r] <= sample;
      slot_r         <= slot_nxt;
      rep_r          <= rep_nxt;
    end
  end

endmodule

### hdl/rsec_front.sv
// Front end: accepts ticks, runs the detectors and queues the events of a tick.
module rsec_front
  import rsec_pkg::*;
#(
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
  parameter int BUMPER_WIDTH  = DEF_BUMPER_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  logic                   in_push,
  output logic                   in_full,
  input  logic [LEVEL_W-1:0]     in_beacon_level,
  input  logic [BUMP_PORT_W-1:0] in_bumper_bits,
  input  logic [BUMP_PORT_W-1:0] in_top_bumper_bits,
  input  logic [LEVEL_W-1:0]     in_track_right_level,
  input  logic [LEVEL_W-1:0]     in_track_left_level,
  input  logic                   q_full,
  output logic                   q_wr,
  output rsec_rec_t              q_data
);

  logic                    accept;
  logic                    beacon_r, beacon_nxt;
  logic                    track_r, track_nxt;
  logic [1:0]              flags_r, flags_nxt;
  logic [BUMPER_WIDTH-1:0] bump_s, top_s;
  logic                    bump_ev, top_ev, beacon_ev, track_ev;
  logic                    r_hi, r_lo, l_hi, l_lo;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  // Bits above the configured bumper width are dropped.
  assign bump_s = BUMPER_WIDTH'(in_bumper_bits);
  assign top_s  = BUMPER_WIDTH'(in_top_bumper_bits);

  rsec_debounce #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .BUMPER_WIDTH  (BUMPER_WIDTH)
  ) u_db_bump (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (accept),
    .sample (bump_s),
    .ev     (bump_ev)
  );

  rsec_debounce #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .BUMPER_WIDTH  (BUMPER_WIDTH)
  ) u_db_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (accept),
    .sample (top_s),
    .ev     (top_ev)
  );

  always_comb begin
    if (in_beacon_level > cfg.beacon_hi) begin
      beacon_nxt = 1'b1;
    end else if (in_beacon_level < cfg.beacon_lo) begin
      beacon_nxt = 1'b0;
    end else begin
      beacon_nxt = beacon_r;
    end
  end

  assign r_hi = in_track_right_level > cfg.track_hi;
  assign r_lo = in_track_right_level < cfg.track_lo;
  assign l_hi = in_track_left_level > cfg.track_hi;
  assign l_lo = in_track_left_level < cfg.track_lo;

  // Side flags move only while some side is above the high level.
  always_comb begin
    flags_nxt = flags_r;
    track_nxt = track_r;
    if (r_hi || l_hi) begin
      track_nxt = 1'b1;
      if (r_hi) begin
        flags_nxt[0] = 1'b1;
      end else if (r_lo) begin
        flags_nxt[0] = 1'b0;
      end
      if (l_hi) begin
        flags_nxt[1] = 1'b1;
      end else if (l_lo) begin
        flags_nxt[1] = 1'b0;
      end
    end else if (r_lo && l_lo) begin
      track_nxt = 1'b0;
    end
  end

  assign beacon_ev = beacon_nxt != beacon_r;
  // Reported flags always equal the held flags after a tick.
  assign track_ev  = (track_nxt != track_r) || (flags_nxt != flags_r);

  always_comb begin
    q_data                   = '0;
    q_data.mask[EVB_BEACON]  = beacon_ev;
    q_data.mask[EVB_BUMPER]  = bump_ev;
    q_data.mask[EVB_TOP]     = top_ev;
    q_data.mask[EVB_TRACK]   = track_ev;
    q_data.beacon_on         = beacon_nxt;
    q_data.bump_val          = VALUE_W'(bump_s);
    q_data.top_val           = VALUE_W'(top_s);
    q_data.track_found       = track_nxt;
    q_data.track_flags       = flags_nxt;
  end

  // Ticks without events never reach the queue.
  assign q_wr = accept && (beacon_ev || bump_ev || top_ev || track_ev);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beacon_r <= 1'b0;
      track_r  <= 1'b0;
      flags_r  <= '0;
    end else if (accept) begin
      beacon_r <= beacon_nxt;
      track_r  <= track_nxt;
      flags_r  <= flags_nxt;
    end
  end

endmodule

### hdl/rsec_fifo.sv
// Short queue of tick records between front and back.
module rsec_fifo
  import rsec_pkg::*;
#(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  rsec_rec_t wr_data,
  output logic      full,
  input  logic      rd_en,
  output rsec_rec_t rd_data,
  output logic      empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  rsec_rec_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [CNT_W-1:0] cnt_r;

  assign full    = cnt_r == CNT_W'(DEPTH);
  assign empty   = cnt_r == '0;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r <= (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (rd_en) begin
        rp_r <= (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !empty)
    else $error("queue read while empty");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && !rd_en) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count did not track a lone write");

endmodule

### hdl/rsec_back.sv
// Back end: splits queued tick records into single events on the result port.
module rsec_back
  import rsec_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  rsec_rec_t          q_data,
  input  logic               q_empty,
  output logic               q_rd,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [KIND_W-1:0]  out_event_kind,
  output logic [VALUE_W-1:0] out_event_value,
  output logic               out_last_event
);

  rsec_rec_t          work_r;
  logic [NUM_EV-1:0]  mask_r, mask_nxt;
  logic               ovalid_r;
  ev_kind_t           kind_r, kind_nxt;
  logic [VALUE_W-1:0] value_r, value_nxt;
  logic               last_r;

  logic               adv, have, use_work;
  rsec_rec_t          src;
  logic [NUM_EV-1:0]  src_mask;

  assign adv      = !ovalid_r || out_pop;
  assign use_work = mask_r != '0;
  assign have     = use_work || !q_empty;
  assign src      = use_work ? work_r : q_data;
  assign src_mask = use_work ? mask_r : q_data.mask;
  assign q_rd     = adv && !use_work && !q_empty;
  // Clear the lowest pending event
  assign mask_nxt = src_mask & (src_mask - 1'b1);

  always_comb begin
    if (src_mask[EVB_BEACON]) begin
      kind_nxt  = src.beacon_on ? EV_BEACON_FOUND : EV_BEACON_LOST;
      value_nxt = '0;
    end else if (src_mask[EVB_BUMPER]) begin
      kind_nxt  = EV_BUMPER;
      value_nxt = src.bump_val;
    end else if (src_mask[EVB_TOP]) begin
      kind_nxt  = EV_TOP_BUMPER;
      value_nxt = src.top_val;
    end else begin
      kind_nxt  = src.track_found ? EV_TRACK_FOUND : EV_TRACK_LOST;
      value_nxt = VALUE_W'(src.track_flags);
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      work_r <= q_data;
    end
    if (adv && have) begin
      kind_r  <= kind_nxt;
      value_r <= value_nxt;
      last_r  <= mask_nxt == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
      mask_r   <= '0;
    end else if (adv) begin
      ovalid_r <= have;
      if (have) begin
        mask_r <= mask_nxt;
      end
    end
  end

  assign out_empty       = !ovalid_r;
  assign out_event_kind  = kind_r;
  assign out_event_value = value_r;
  assign out_last_event  = last_r;

  a_pending_shown: assert property (@(posedge clk) disable iff (!rst_n)
    (mask_r != '0) |-> ovalid_r)
    else $error("events pending behind an empty output");

  a_take_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd |-> (mask_r == '0))
    else $error("record taken while previous one still pending");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !out_last_event) |-> (mask_r != '0))
    else $error("non-final event with nothing left of its tick");

endmodule

### bench/robot_sensor_event_conditioner_unit_tb.sv
// Self-checking testbench for the robot sensor event conditioner.
`timescale 1ns / 1ps

module robot_sensor_event_conditioner_unit_tb;
  import rsec_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int LEVEL_MAX    = (1 << LEVEL_W) - 1;
  localparam int INDEX_MAX    = (1 << CFG_INDEX_W) - 1;
  localparam int BUMP_MAX     = (1 << BUMP_PORT_W) - 1;
  // Settling time after the last pop: enough for a zero-event tick still in
  // flight to clear before thresholds change.
  localparam int SETTLE_CYCLES = 24;
  // Longest legal quiet stretch is the receiver hold-off.
  localparam int STUCK_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 250;
  localparam int BUMP_CH       = 0;
  localparam int TOP_CH        = 1;

  typedef struct packed {
    logic [LEVEL_W-1:0]     beacon;
    logic [BUMP_PORT_W-1:0] bump;
    logic [BUMP_PORT_W-1:0] top;
    logic [LEVEL_W-1:0]     right;
    logic [LEVEL_W-1:0]     left;
  } tick_t;

  typedef struct packed {
    ev_kind_t           kind;
    logic [VALUE_W-1:0] value;
    logic               last;
  } sensor_ev_t;

  // DUT connections; every input starts at a known value
  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_push = 1'b0;
  logic                   in_full;
  logic [LEVEL_W-1:0]     in_beacon_level = '0;
  logic [BUMP_PORT_W-1:0] in_bumper_bits = '0;
  logic [BUMP_PORT_W-1:0] in_top_bumper_bits = '0;
  logic [LEVEL_W-1:0]     in_track_right_level = '0;
  logic [LEVEL_W-1:0]     in_track_left_level = '0;
  logic                   out_empty;
  logic                   out_pop = 1'b0;
  logic [KIND_W-1:0]      out_event_kind;
  logic [VALUE_W-1:0]     out_event_value;
  logic                   out_last_event;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [LEVEL_W-1:0]     cfg_data = '0;

  robot_sensor_event_conditioner_unit u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_beacon_level      (in_beacon_level),
    .in_bumper_bits       (in_bumper_bits),
    .in_top_bumper_bits   (in_top_bumper_bits),
    .in_track_right_level (in_track_right_level),
    .in_track_left_level  (in_track_left_level),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_event_kind       (out_event_kind),
    .out_event_value      (out_event_value),
    .out_last_event       (out_last_event),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predicted state of the conditioner, a private copy kept in step with the
  // ticks that the block has taken.
  // ---------------------------------------------------------------------------
  cfg_t                   thr;
  logic                   beacon_seen;
  logic                   track_seen;
  logic [1:0]             side_flags;
  logic [1:0]             flags_sent;
  logic [BUMP_PORT_W-1:0] db_hist [2][DEF_HISTORY_DEPTH];
  int                     db_slot [2];
  logic [BUMP_PORT_W-1:0] db_sent [2];

  sensor_ev_t tick_evs[$];     // events of the tick being predicted
  sensor_ev_t events_due[$];   // events predicted but not yet popped

  // Bookkeeping
  int unsigned mismatches;
  int unsigned ticks_sent;
  int unsigned events_checked;
  int unsigned cfg_writes;
  int unsigned settings_run;
  bit          steady;          // no random gaps on either side while set
  int unsigned rx_hold;         // receiver hold-off, counted down by the receiver
  int unsigned pop_gap;
  int unsigned stuck_cycles;

  // Stimulus run state for the two bumper sets
  int                     run_left [2];
  logic [BUMP_PORT_W-1:0] run_val [2];

  function automatic void clear_prediction();
    thr.beacon_hi = RST_BEACON_HIGH;
    thr.beacon_lo = RST_BEACON_LOW;
    thr.track_hi  = RST_TRACK_HIGH;
    thr.track_lo  = RST_TRACK_LOW;
    beacon_seen   = 1'b0;
    track_seen    = 1'b0;
    side_flags    = '0;
    flags_sent    = '0;
    for (int c = 0; c < 2; c++) begin
      for (int i = 0; i < DEF_HISTORY_DEPTH; i++) db_hist[c][i] = '0;
      db_slot[c]  = 0;
      db_sent[c]  = '0;
      run_left[c] = 0;
      run_val[c]  = '0;
    end
  endfunction

  function automatic void apply_threshold(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [LEVEL_W-1:0] val);
    case (idx)
      CFG_BEACON_HIGH: thr.beacon_hi = val;
      CFG_BEACON_LOW:  thr.beacon_lo = val;
      CFG_TRACK_HIGH:  thr.track_hi  = val;
      CFG_TRACK_LOW:   thr.track_lo  = val;
      default: ;  // unmapped index: dropped
    endcase
  endfunction

  // Debounce one bumper set; returns 1 when a new stable value is reported.
  function automatic logic debounce(input int ch, input logic [BUMP_PORT_W-1:0] s);
    logic stable;
    stable = 1'b1;
    db_hist[ch][db_slot[ch]] = s;
    db_slot[ch] = (db_slot[ch] + 1) % DEF_HISTORY_DEPTH;
    for (int i = 0; i < DEF_HISTORY_DEPTH; i++)
      if (db_hist[ch][i] != s) stable = 1'b0;
    if (s == '0) db_sent[ch] = '0;
    if (stable && s != db_sent[ch] && s != '0) begin
      db_sent[ch] = s;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void add_event(input ev_kind_t kind, input logic [VALUE_W-1:0] value);
    sensor_ev_t ev;
    ev.kind  = kind;
    ev.value = value;
    ev.last  = 1'b0;
    tick_evs.push_back(ev);
  endfunction

  // Work out the events of one accepted tick and queue them.
  function automatic void condition_tick(input tick_t t);
    logic beacon_nx;
    logic track_nx;
    logic bump_ev;
    logic top_ev;
    tick_evs.delete();
    beacon_nx = beacon_seen;
    track_nx  = track_seen;
    if (t.beacon > thr.beacon_hi)      beacon_nx = 1'b1;
    else if (t.beacon < thr.beacon_lo) beacon_nx = 1'b0;
    bump_ev = debounce(BUMP_CH, t.bump);
    top_ev  = debounce(TOP_CH, t.top);
    // High test wins even with crossed thresholds
    if (t.right > thr.track_hi || t.left > thr.track_hi) begin
      track_nx = 1'b1;
      if (t.right > thr.track_hi)     side_flags[0] = 1'b1;
      else if (t.right < thr.track_lo) side_flags[0] = 1'b0;
      if (t.left > thr.track_hi)      side_flags[1] = 1'b1;
      else if (t.left < thr.track_lo)  side_flags[1] = 1'b0;
    end else if (t.right < thr.track_lo && t.left < thr.track_lo) begin
      track_nx = 1'b0;  // lost; side flags kept
    end
    if (beacon_nx != beacon_seen) begin
      beacon_seen = beacon_nx;
      add_event(beacon_nx ? EV_BEACON_FOUND : EV_BEACON_LOST, '0);
    end
    if (bump_ev) add_event(EV_BUMPER, VALUE_W'(db_sent[BUMP_CH]));
    if (top_ev)  add_event(EV_TOP_BUMPER, VALUE_W'(db_sent[TOP_CH]));
    if (track_nx != track_seen || flags_sent != side_flags) begin
      track_seen = track_nx;
      flags_sent = side_flags;
      add_event(track_nx ? EV_TRACK_FOUND : EV_TRACK_LOST, VALUE_W'(side_flags));
    end
    if (tick_evs.size() != 0) tick_evs[tick_evs.size() - 1].last = 1'b1;
    foreach (tick_evs[i]) events_due.push_back(tick_evs[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly short gaps, a few long ones; none while steady is set.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 96) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Levels cluster around the thresholds, with the rails and full range too.
  function automatic logic [LEVEL_W-1:0] pick_level(input logic [LEVEL_W-1:0] hi,
                                                    input logic [LEVEL_W-1:0] lo);
    int v;
    case ($urandom_range(9))
      0, 1, 2: v = $urandom_range(LEVEL_MAX);
      3, 4:    v = int'(hi) + int'($urandom_range(4)) - 2;
      5, 6:    v = int'(lo) + int'($urandom_range(4)) - 2;
      7:       v = 0;
      8:       v = LEVEL_MAX;
      default: v = $urandom_range(LEVEL_MAX);
    endcase
    if (v < 0) v = 0;
    if (v > LEVEL_MAX) v = LEVEL_MAX;
    return LEVEL_W'(v);
  endfunction

  // Bumper samples come in runs: mostly runs long enough to debounce, some
  // broken short runs and some single-tick noise.
  function automatic logic [BUMP_PORT_W-1:0] next_bump(input int ch);
    int unsigned r;
    if (run_left[ch] == 0) begin
      r = $urandom_range(99);
      if (r < 60) begin
        if (r < 10)      run_val[ch] = '0;
        else if (r >= 20) run_val[ch] = BUMP_PORT_W'($urandom_range(BUMP_MAX));
        // else repeat the previous value, which may already be reported
        run_left[ch] = $urandom_range(11, DEF_HISTORY_DEPTH);
      end else if (r < 85) begin
        run_val[ch]  = BUMP_PORT_W'($urandom_range(BUMP_MAX));
        run_left[ch] = $urandom_range(DEF_HISTORY_DEPTH - 1, 1);
      end else begin
        run_val[ch]  = BUMP_PORT_W'($urandom_range(BUMP_MAX));
        run_left[ch] = 1;
      end
    end
    run_left[ch]--;
    return run_val[ch];
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    t.beacon = pick_level(thr.beacon_hi, thr.beacon_lo);
    t.bump   = next_bump(BUMP_CH);
    t.top    = next_bump(TOP_CH);
    t.right  = pick_level(thr.track_hi, thr.track_lo);
    t.left   = pick_level(thr.track_hi, thr.track_lo);
    return t;
  endfunction

  function automatic tick_t make_tick(input int beacon, input int bump, input int top,
                                      input int right, input int left);
    tick_t t;
    t.beacon = LEVEL_W'(beacon);
    t.bump   = BUMP_PORT_W'(bump);
    t.top    = BUMP_PORT_W'(top);
    t.right  = LEVEL_W'(right);
    t.left   = LEVEL_W'(left);
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel tasks. All drive at the rising edge. push is left high after a
  // transfer when no gap follows, so back-to-back ticks never see it dropped
  // and raised in the same step.
  // ---------------------------------------------------------------------------
  task automatic send_tick(input tick_t t);
    int unsigned gap;
    in_push              <= 1'b1;
    in_beacon_level      <= t.beacon;
    in_bumper_bits       <= t.bump;
    in_top_bumper_bits   <= t.top;
    in_track_right_level <= t.right;
    in_track_left_level  <= t.left;
    @(posedge clk);
    while (in_full) @(posedge clk);
    condition_tick(t);
    ticks_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random(input int n);
    repeat (n) send_tick(random_tick());
  endtask

  // Release the input and wait until every predicted event has been popped,
  // then let a trailing zero-event tick work its way through.
  task automatic drain_events();
    in_push <= 1'b0;
    while (events_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [CFG_INDEX_W-1:0] idx,
                                 input logic [LEVEL_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_threshold(idx, val);
    cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Idle the block, load a full threshold set plus a write to an unmapped
  // index, then run random ticks against it.
  task automatic run_setting(input int bh, input int bl, input int th, input int tl,
                             input int n);
    drain_events();
    write_threshold(CFG_BEACON_HIGH, LEVEL_W'(bh));
    write_threshold(CFG_BEACON_LOW, LEVEL_W'(bl));
    write_threshold(CFG_TRACK_HIGH, LEVEL_W'(th));
    write_threshold(CFG_TRACK_LOW, LEVEL_W'(tl));
    write_threshold(CFG_INDEX_W'($urandom_range(INDEX_MAX, CFG_TRACK_LOW + 1)),
                    LEVEL_W'($urandom_range(LEVEL_MAX)));
    settings_run++;
    send_random(n);
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: pops with random gaps (or holds off when asked) and checks every
  // event transfer against the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic check_event();
    sensor_ev_t exp;
    events_checked++;
    if (events_due.size() == 0) begin
      report_mismatch($sformatf("unexpected event kind %0d value 0x%02h",
                                out_event_kind, out_event_value));
      return;
    end
    exp = events_due.pop_front();
    if (out_event_kind !== exp.kind)
      report_mismatch($sformatf("event_kind got %0d, want %0d", out_event_kind, exp.kind));
    if (out_event_value !== exp.value)
      report_mismatch($sformatf("event_value got 0x%02h, want 0x%02h (kind %0d)",
                                out_event_value, exp.value, exp.kind));
    if (out_last_event !== exp.last)
      report_mismatch($sformatf("last_event got %0b, want %0b (kind %0d)",
                                out_last_event, exp.last, exp.kind));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) check_event();
      if (rx_hold != 0) begin
        rx_hold--;
        out_pop <= 1'b0;
      end else if (pop_gap != 0) begin
        pop_gap--;
        out_pop <= 1'b0;
      end else begin
        if (out_pop && !out_empty) pop_gap = pick_gap();
        out_pop <= (pop_gap == 0);
      end
    end
  end

  // Watchdog: too long without any transfer on any channel ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles, %0d events still due",
               STUCK_LIMIT, events_due.size());
      $display("Some tests failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Beacon hysteresis at the reset thresholds: equal to high is not found,
  // equal to low is not lost, plus both rails.
  task automatic test_beacon_hysteresis();
    send_tick(make_tick(750, 0, 0, 0, 0));
    send_tick(make_tick(751, 0, 0, 0, 0));
    send_tick(make_tick(350, 0, 0, 0, 0));
    send_tick(make_tick(349, 0, 0, 0, 0));
    send_tick(make_tick(LEVEL_MAX, 0, 0, 0, 0));
    send_tick(make_tick(0, 0, 0, 0, 0));
  endtask

  // Track wire: each side found alone, the in-between band keeps status,
  // both below low loses the wire but keeps the side flags.
  task automatic test_track_hysteresis();
    send_tick(make_tick(0, 0, 0, 401, 0));
    send_tick(make_tick(0, 0, 0, 0, 401));
    send_tick(make_tick(0, 0, 0, 400, 300));
    send_tick(make_tick(0, 0, 0, 299, 299));
    send_tick(make_tick(0, 0, 0, LEVEL_MAX, LEVEL_MAX));
    send_tick(make_tick(0, 0, 0, 350, LEVEL_MAX));
  endtask

  // Debounce needs a full history of the same sample; the eighth tick also
  // finds beacon and track so one tick yields all four events. A zero sample
  // then clears what was reported.
  task automatic test_bumper_debounce();
    repeat (DEF_HISTORY_DEPTH - 1) send_tick(make_tick(0, BUMP_MAX, 1, 0, 0));
    send_tick(make_tick(LEVEL_MAX, BUMP_MAX, 1, LEVEL_MAX, 0));
    send_tick(make_tick(0, 0, 0, 0, 0));
  endtask

  // Threshold settings: all zero, all max, crossed, two random, then reset.
  task automatic test_thresholds();
    run_setting(0, 0, 0, 0, 30);
    run_setting(LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, 30);
    run_setting(100, 900, 200, 800, 30);
    run_setting($urandom_range(LEVEL_MAX), $urandom_range(LEVEL_MAX),
                $urandom_range(LEVEL_MAX), $urandom_range(LEVEL_MAX), 30);
    run_setting($urandom_range(LEVEL_MAX), $urandom_range(LEVEL_MAX),
                $urandom_range(LEVEL_MAX), $urandom_range(LEVEL_MAX), 30);
    run_setting(RST_BEACON_HIGH, RST_BEACON_LOW, RST_TRACK_HIGH, RST_TRACK_LOW, 30);
  endtask

  // Receiver stalls for a long stretch while the sender keeps pushing, so the
  // block fills and holds full; afterwards the sender waits for a full drain.
  task automatic test_backpressure();
    drain_events();
    steady  = 1'b1;
    rx_hold = HOLD_CYCLES;
    send_random(40);
    steady  = 1'b0;
    drain_events();
  endtask

  // No idle cycles on either side.
  task automatic test_streaming();
    steady = 1'b1;
    send_random(60);
    steady = 1'b0;
  endtask

  task automatic test_random_mix();
    send_random(112);
  endtask

  initial begin
    clear_prediction();
    mismatches     = 0;
    ticks_sent     = 0;
    events_checked = 0;
    cfg_writes     = 0;
    settings_run   = 0;
    steady         = 1'b0;
    rx_hold        = 0;
    pop_gap        = 0;
    stuck_cycles   = 0;

    // Synchronous reset held, then released once
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_beacon_hysteresis();
    test_track_hysteresis();
    test_bumper_debounce();
    test_thresholds();
    test_backpressure();
    test_streaming();
    test_random_mix();
    drain_events();

    $display("Ran %0d ticks and checked %0d events over %0d threshold settings (%0d writes),",
             ticks_sent, events_checked, settings_run, cfg_writes);
    $display("including a long output stall with input back-pressure and a no-idle stream.");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
